@@ rtl/core/bsfp_pkg.sv @@
// Shared types, character codes and digit decoder for the bit string field parser.
`timescale 1ns / 1ps

package bsfp_pkg;

    // Parse phase of the field in progress
    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_TRAIL  = 2'd2,
        PH_DRAIN  = 2'd3
    } phase_t;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_RADIX_BITS  = 3'd0;
    localparam logic [2:0] CFG_BIT_LENGTH  = 3'd1;
    localparam logic [2:0] CFG_FIELD_WIDTH = 3'd2;
    localparam logic [2:0] CFG_DELIM_MASK  = 3'd3;

    // Effective radix codes (bits per digit)
    localparam logic [2:0] RADIX_BIN  = 3'd1;
    localparam logic [2:0] RADIX_QUAD = 3'd2;
    localparam logic [2:0] RADIX_OCT  = 3'd3;
    localparam logic [2:0] RADIX_HEX  = 3'd4;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_THREE   = 8'h33;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] HEX_GAP    = 8'd7;   // distance from '9'+1 to 'A'

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    // Field state apart from the accumulator
    typedef struct packed {
        phase_t     phase;
        logic [6:0] bits_taken;
        logic [7:0] chars_left;
        logic [1:0] err;
    } ctl_t;

    // Effective (range-corrected) configuration
    typedef struct packed {
        logic [2:0] radix;
        logic [6:0] len;
        logic [7:0] width;
        logic [1:0] delim;
    } cfg_t;

    function automatic digit_t digit_decode(input logic [7:0] c, input logic [2:0] radix);
        digit_t d;
        d = '{valid: 1'b0, value: 4'd0};
        unique case (radix)
            RADIX_BIN: begin
                d.valid = (c >= CH_ZERO) && (c <= CH_ONE);
                d.value = 4'(c - CH_ZERO);
            end
            RADIX_QUAD: begin
                d.valid = (c >= CH_ZERO) && (c <= CH_THREE);
                d.value = 4'(c - CH_ZERO);
            end
            RADIX_OCT: begin
                d.valid = (c >= CH_ZERO) && (c <= CH_SEVEN);
                d.value = 4'(c - CH_ZERO);
            end
            default: begin
                if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
                    d.valid = 1'b1;
                    d.value = 4'(c - CH_ZERO);
                end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) begin
                    d.valid = 1'b1;
                    d.value = 4'(c - CH_ZERO - HEX_GAP);
                end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
                    d.valid = 1'b1;
                    d.value = 4'(c - CH_LOWER_A + 8'd10);
                end
            end
        endcase
        if (!d.valid) begin
            d.value = 4'd0;
        end
        return d;
    endfunction

endpackage

@@ rtl/core/bsfp_step.sv @@
// Per-character step logic: phase machine, digit insertion and result forming.
`timescale 1ns / 1ps

module bsfp_step #(
    parameter int VALUE_BITS = 64
) (
    input  bsfp_pkg::ctl_t          ctl_i,
    input  logic [VALUE_BITS-1:0]   accum_i,
    input  bsfp_pkg::cfg_t          cfg_i,
    input  logic [7:0]              char_i,
    input  logic                    no_more_i,
    output bsfp_pkg::ctl_t          ctl_o,
    output logic [VALUE_BITS-1:0]   accum_o,
    output logic                    res_valid_o,
    output logic [VALUE_BITS-1:0]   res_value_o,
    output logic [1:0]              res_status_o
);

    bsfp_pkg::digit_t          dig;
    bsfp_pkg::phase_t          phase_step;
    logic                      is_space;
    logic                      delim_hit;
    logic                      counted;
    logic [6:0]                bits_sum;
    logic                      full;
    logic [6:0]                excess;
    logic [3:0]                pad_mask;
    logic                      pad_bad;
    logic                      take;
    logic [VALUE_BITS+7:0]     placed;
    bsfp_pkg::ctl_t            ctl_upd;
    logic [VALUE_BITS-1:0]     accum_upd;

    assign dig       = bsfp_pkg::digit_decode(char_i, cfg_i.radix);
    assign is_space  = (char_i == bsfp_pkg::CH_SPACE);
    assign delim_hit = (cfg_i.delim[0] && (char_i == bsfp_pkg::CH_COMMA)) ||
                       (cfg_i.delim[1] && (char_i == bsfp_pkg::CH_NEWLINE));
    assign counted   = !no_more_i && !delim_hit;

    assign bits_sum  = ctl_i.bits_taken + 7'(cfg_i.radix);
    assign full      = (bits_sum >= cfg_i.len);
    assign excess    = bits_sum - cfg_i.len;
    assign pad_mask  = 4'((5'd1 << excess[1:0]) - 5'd1);
    assign pad_bad   = full && ((dig.value & pad_mask) != 4'd0);
    assign take      = !is_space && dig.valid &&
                       ((ctl_i.phase == bsfp_pkg::PH_LEAD) ||
                        (ctl_i.phase == bsfp_pkg::PH_DIGITS));

    // Place the digit so that its top bit lands at VALUE_BITS-1-bits_taken;
    // bits falling below bit 0 drop off the low end.
    assign placed = {dig.value, (VALUE_BITS + 4)'(0)} >> bits_sum;

    // Next phase for a counted character
    always_comb begin
        phase_step = ctl_i.phase;
        unique case (ctl_i.phase)
            bsfp_pkg::PH_LEAD: begin
                if (!is_space) begin
                    if (!dig.valid) begin
                        phase_step = bsfp_pkg::PH_DRAIN;
                    end else if (full) begin
                        phase_step = bsfp_pkg::PH_TRAIL;
                    end else begin
                        phase_step = bsfp_pkg::PH_DIGITS;
                    end
                end
            end
            bsfp_pkg::PH_DIGITS: begin
                if (is_space) begin
                    phase_step = bsfp_pkg::PH_TRAIL;
                end else if (!dig.valid) begin
                    phase_step = bsfp_pkg::PH_DRAIN;
                end else if (full) begin
                    phase_step = bsfp_pkg::PH_TRAIL;
                end
            end
            bsfp_pkg::PH_TRAIL: begin
                if (!is_space) begin
                    phase_step = bsfp_pkg::PH_DRAIN;
                end
            end
            default: begin
                phase_step = bsfp_pkg::PH_DRAIN;
            end
        endcase
    end

    // Datapath, error code and result
    always_comb begin
        ctl_upd   = ctl_i;
        accum_upd = accum_i;
        if (counted) begin
            ctl_upd.chars_left = ctl_i.chars_left - 8'd1;
            ctl_upd.phase      = phase_step;
            if (take) begin
                accum_upd          = accum_i | placed[VALUE_BITS+3:4];
                ctl_upd.bits_taken = bits_sum;
                if (pad_bad) begin
                    ctl_upd.err = bsfp_pkg::ST_TOO_LONG;
                end
            end else if (!is_space) begin
                if (ctl_i.phase == bsfp_pkg::PH_TRAIL) begin
                    ctl_upd.err = dig.valid ? bsfp_pkg::ST_TOO_LONG : bsfp_pkg::ST_ILLEGAL;
                end else if (ctl_i.phase != bsfp_pkg::PH_DRAIN) begin
                    ctl_upd.err = bsfp_pkg::ST_ILLEGAL;
                end
            end
        end

        res_valid_o = !counted || (ctl_upd.chars_left == 8'd0);

        if (ctl_upd.phase == bsfp_pkg::PH_LEAD) begin
            res_status_o = bsfp_pkg::ST_EMPTY;
            res_value_o  = '0;
        end else if (ctl_upd.err != bsfp_pkg::ST_OK) begin
            res_status_o = ctl_upd.err;
            res_value_o  = '0;
        end else begin
            res_status_o = bsfp_pkg::ST_OK;
            res_value_o  = accum_upd;
        end

        // Restart the field once it has ended
        if (res_valid_o) begin
            ctl_o   = '{phase: bsfp_pkg::PH_LEAD, bits_taken: 7'd0,
                        chars_left: cfg_i.width, err: bsfp_pkg::ST_OK};
            accum_o = '0;
        end else begin
            ctl_o   = ctl_upd;
            accum_o = accum_upd;
        end
    end

endmodule

@@ rtl/core/bit_string_field_parser_unit.sv @@
// Top level of the bit string field parser: config registers, field state, output register.
// A result appears on m_tvalid in the cycle after the word that ends its field is accepted.
// Throughput: one character word per cycle while the input is not stalled; the combinational step logic sets this.
// The input stalls only while the output register holds a result not yet taken.
// Reset (aresetn low, synchronous): radix 1, length 1, width 1, no delimiters, empty field.
`timescale 1ns / 1ps

module bit_string_field_parser_unit #(
    parameter int VALUE_BITS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // character input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] char_code
    input  logic                              s_tuser,   // [0] no_more
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((VALUE_BITS+7)/8)*8-1:0]   m_tdata,   // [VALUE_BITS-1:0] bits_value, zero pad
    output logic [1:0]                        m_tuser,   // [1:0] status
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [7:0]                        cfg_data
);

    localparam int TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

    // Configuration registers, raw as written
    logic [2:0] radix_bits_reg;
    logic [6:0] bit_length_reg;
    logic [7:0] field_width_reg;
    logic [1:0] delim_mask_reg;

    // Field state
    bsfp_pkg::ctl_t          ctl_reg, ctl_next;
    logic [VALUE_BITS-1:0]   accum_reg, accum_next;

    // Output register
    logic                    m_tvalid_reg;
    logic [VALUE_BITS-1:0]   m_value_reg;
    logic [1:0]              m_status_reg;

    bsfp_pkg::cfg_t          cfg_eff;
    logic                    s_accept;
    logic                    cfg_wr;
    logic                    res_valid;
    logic [VALUE_BITS-1:0]   res_value;
    logic [1:0]              res_status;
    logic [7:0]              width_sel;
    logic [7:0]              restart_width;

    // Accept a character whenever the output register is free or being emptied
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Range-correct the configuration: radix zero acts as binary, above hex as hex;
    // length zero acts as one and saturates at VALUE_BITS; width zero acts as one.
    always_comb begin
        cfg_eff.delim = delim_mask_reg;
        if (radix_bits_reg == 3'd0) begin
            cfg_eff.radix = bsfp_pkg::RADIX_BIN;
        end else if (radix_bits_reg > bsfp_pkg::RADIX_HEX) begin
            cfg_eff.radix = bsfp_pkg::RADIX_HEX;
        end else begin
            cfg_eff.radix = radix_bits_reg;
        end
        if (bit_length_reg == 7'd0) begin
            cfg_eff.len = 7'd1;
        end else if (bit_length_reg > 7'(VALUE_BITS)) begin
            cfg_eff.len = 7'(VALUE_BITS);
        end else begin
            cfg_eff.len = bit_length_reg;
        end
        cfg_eff.width = (field_width_reg == 8'd0) ? 8'd1 : field_width_reg;
    end

    // A config write to a known index restarts the field; take the width that will be in force after it
    assign width_sel     = (cfg_index == bsfp_pkg::CFG_FIELD_WIDTH) ? cfg_data : field_width_reg;
    assign restart_width = (width_sel == 8'd0) ? 8'd1 : width_sel;

    bsfp_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .ctl_i        (ctl_reg),
        .accum_i      (accum_reg),
        .cfg_i        (cfg_eff),
        .char_i       (s_tdata),
        .no_more_i    (s_tuser),
        .ctl_o        (ctl_next),
        .accum_o      (accum_next),
        .res_valid_o  (res_valid),
        .res_value_o  (res_value),
        .res_status_o (res_status)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_bits_reg  <= bsfp_pkg::RADIX_BIN;
            bit_length_reg  <= 7'd1;
            field_width_reg <= 8'd1;
            delim_mask_reg  <= 2'd0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                bsfp_pkg::CFG_RADIX_BITS:  radix_bits_reg  <= cfg_data[2:0];
                bsfp_pkg::CFG_BIT_LENGTH:  bit_length_reg  <= cfg_data[6:0];
                bsfp_pkg::CFG_FIELD_WIDTH: field_width_reg <= cfg_data;
                bsfp_pkg::CFG_DELIM_MASK:  delim_mask_reg  <= cfg_data[1:0];
                default: ;  // unknown index: drop the word
            endcase
        end
    end

    // Field state: restart on a known config write, else advance on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg   <= '{phase: bsfp_pkg::PH_LEAD, bits_taken: 7'd0,
                           chars_left: 8'd1, err: bsfp_pkg::ST_OK};
            accum_reg <= '0;
        end else if (cfg_wr && (cfg_index <= bsfp_pkg::CFG_DELIM_MASK)) begin
            ctl_reg   <= '{phase: bsfp_pkg::PH_LEAD, bits_taken: 7'd0,
                           chars_left: restart_width, err: bsfp_pkg::ST_OK};
            accum_reg <= '0;
        end else if (s_accept) begin
            ctl_reg   <= ctl_next;
            accum_reg <= accum_next;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept && res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            m_value_reg  <= res_value;
            m_status_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_BITS'(m_value_reg);
    assign m_tuser  = m_status_reg;

`ifndef SYNTHESIS
    // An error or empty result never carries a value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg != bsfp_pkg::ST_OK)) |-> (m_value_reg == '0))
        else $error("non-ok result with nonzero value");

    // End of input always yields a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser) |=> m_tvalid_reg)
        else $error("no result after end of input");

    // While still skipping leading spaces, no digit has been gathered
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_reg.phase == bsfp_pkg::PH_LEAD) |-> ((ctl_reg.bits_taken == 7'd0) && (accum_reg == '0)))
        else $error("digits held in leading-space phase");

    // A field in progress always has characters left
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.chars_left != 8'd0)
        else $error("character count ran out without ending the field");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for bit_string_field_parser_unit: character words in, parsed fields checked.
`timescale 1ns / 1ps

module tb_top;
    import bsfp_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam logic [2:0] CFG_UNUSED_FIRST = CFG_DELIM_MASK + 3'd1;
    localparam logic [1:0] DELIM_COMMA   = 2'b01;
    localparam logic [1:0] DELIM_NEWLINE = 2'b10;
    localparam logic [1:0] DELIM_BOTH    = DELIM_COMMA | DELIM_NEWLINE;
    localparam logic [1:0] DELIM_NONE    = 2'b00;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } field_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    // register copies and field state of the parser as predicted
    logic [2:0]  reg_radix;
    logic [6:0]  reg_length;
    logic [7:0]  reg_width;
    logic [1:0]  reg_delim;
    phase_t      fld_phase;
    logic [63:0] fld_accum;
    logic [6:0]  fld_bits;
    logic [7:0]  fld_left;
    logic [1:0]  fld_err;
    bit          field_open;

    field_result_t expected_fields[$];
    int          fail_count = 0;
    int          chars_sent = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          send_gaps = 1'b1;
    bit          recv_stalls = 1'b1;

    bit_string_field_parser_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bit_string_field_parser_unit verification failed");
            $finish;
        end
    end

    // Result side: stall m_tready in random bursts while stalls are enabled
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (recv_stalls && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 14);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare every result word taken against the oldest field still pending
    always @(posedge aclk) begin : check_result
        field_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_fields.size() == 0) begin
                $display("%0t: unexpected result: value %h status %0d", $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = expected_fields.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: bits_value expected %h actual %h", $time, want.value, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- field predictor ----------------

    function automatic int eff_radix();
        if (reg_radix == 3'd0) return 1;
        if (reg_radix > RADIX_HEX) return 4;
        return int'(reg_radix);
    endfunction

    function automatic int eff_len();
        if (reg_length == 7'd0) return 1;
        if (reg_length > 7'd64) return 64;
        return int'(reg_length);
    endfunction

    function automatic int eff_width();
        return (reg_width == 8'd0) ? 1 : int'(reg_width);
    endfunction

    function automatic int digit_of(input logic [7:0] c, input int base);
        if (base == RADIX_BIN) return (c >= CH_ZERO && c <= CH_ONE) ? int'(c - CH_ZERO) : -1;
        if (base == RADIX_QUAD) return (c >= CH_ZERO && c <= CH_THREE) ? int'(c - CH_ZERO) : -1;
        if (base == RADIX_OCT) return (c >= CH_ZERO && c <= CH_SEVEN) ? int'(c - CH_ZERO) : -1;
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
        return -1;
    endfunction

    task automatic field_restart();
        fld_phase  = PH_LEAD;
        fld_accum  = 64'd0;
        fld_bits   = 7'd0;
        fld_left   = 8'(eff_width());
        fld_err    = ST_OK;
        field_open = 1'b0;
    endtask

    // Place one digit below the bits already held; flag padding bits past the length
    task automatic take_digit(input int d, input int base);
        int len;
        int pos;
        int excess;
        len = eff_len();
        pos = int'(fld_bits);
        if (pos + base <= 64) fld_accum |= 64'(d) << (64 - pos - base);
        else if (pos < 64) fld_accum |= 64'(d) >> (pos + base - 64);
        fld_bits = 7'(pos + base);
        if (int'(fld_bits) >= len) begin
            excess = int'(fld_bits) - len;
            if (excess < base && (d & ((1 << excess) - 1)) != 0) fld_err = ST_TOO_LONG;
            fld_phase = PH_TRAIL;
        end
    endtask

    task automatic parse_char(input logic [7:0] c, input logic eof);
        int base;
        int d;
        bit ends;
        field_result_t res;
        ends = 1'b0;
        if (eof) begin
            ends = 1'b1;
        end else if ((reg_delim[0] && c == CH_COMMA) || (reg_delim[1] && c == CH_NEWLINE)) begin
            ends = 1'b1;
        end else begin
            base = eff_radix();
            d = digit_of(c, base);
            fld_left = fld_left - 8'd1;
            field_open = 1'b1;
            case (fld_phase)
                PH_LEAD: begin
                    if (c != CH_SPACE) begin
                        if (d >= 0) begin
                            fld_phase = PH_DIGITS;
                            take_digit(d, base);
                        end else begin
                            fld_err   = ST_ILLEGAL;
                            fld_phase = PH_DRAIN;
                        end
                    end
                end
                PH_DIGITS: begin
                    if (c == CH_SPACE) begin
                        fld_phase = PH_TRAIL;
                    end else if (d >= 0) begin
                        take_digit(d, base);
                    end else begin
                        fld_err   = ST_ILLEGAL;
                        fld_phase = PH_DRAIN;
                    end
                end
                PH_TRAIL: begin
                    if (c != CH_SPACE) begin
                        fld_err   = (d >= 0) ? ST_TOO_LONG : ST_ILLEGAL;
                        fld_phase = PH_DRAIN;
                    end
                end
                default: begin
                end
            endcase
            if (fld_left == 8'd0) ends = 1'b1;
        end
        if (ends) begin
            if (fld_phase == PH_LEAD) res = '{value: 64'd0, status: ST_EMPTY};
            else if (fld_err != ST_OK) res = '{value: 64'd0, status: fld_err};
            else res = '{value: fld_accum, status: ST_OK};
            expected_fields.push_back(res);
            field_restart();
        end
    endtask

    // ---------------- drivers ----------------

    task automatic send_char(input logic [7:0] c, input logic eof);
        int idle;
        if (send_gaps && $urandom_range(0, 7) == 0) begin
            idle = $urandom_range(1, 15);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (idle - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eof;
        do @(posedge aclk); while (!s_tready);
        parse_char(c, eof);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
    endtask

    // Hold the sender until every pending field has come out, then allow for latency
    task automatic wait_fields_done();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_RADIX_BITS:  reg_radix  = data[2:0];
            CFG_BIT_LENGTH:  reg_length = data[6:0];
            CFG_FIELD_WIDTH: reg_width  = data;
            CFG_DELIM_MASK:  reg_delim  = data[1:0];
            default: begin
            end
        endcase
        // any listed register restarts the field; unused indexes leave it alone
        if (idx <= CFG_DELIM_MASK) field_restart();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_format(input logic [2:0] radix, input logic [6:0] len,
                              input logic [7:0] width, input logic [1:0] delim);
        wait_fields_done();
        write_reg(CFG_RADIX_BITS, 8'(radix));
        write_reg(CFG_BIT_LENGTH, 8'(len));
        write_reg(CFG_FIELD_WIDTH, width);
        write_reg(CFG_DELIM_MASK, 8'(delim));
    endtask

    // ---------------- random field generation ----------------

    function automatic logic [7:0] digit_char(input int base);
        int val;
        val = $urandom_range(0, (1 << base) - 1);
        if (val >= 10) return (($urandom_range(0, 1) == 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(val - 10);
        return CH_ZERO + 8'(val);
    endfunction

    function automatic logic [7:0] stray_char(input int base);
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: begin
                if (base == RADIX_HEX) begin
                    return ($urandom_range(0, 1) == 1) ? CH_UPPER_F + 8'd1 : CH_LOWER_F + 8'd1;
                end
                return CH_ZERO + 8'(1 << base);
            end
            2: return CH_COMMA;
            default: return CH_NEWLINE;
        endcase
    endfunction

    // Mostly well-formed fields with random digits; some with an extra digit, a stray
    // character, a digit after trailing spaces, pure noise or nothing at all
    task automatic send_random_field();
        int base;
        int ndig;
        int kind;
        int n;
        int lead;
        int trail;
        int bad_at;
        int t;
        base   = eff_radix();
        ndig   = (eff_len() + base - 1) / base;
        kind   = $urandom_range(0, 19);
        lead   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        trail  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        n      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, ndig) : ndig;
        if (kind == 13) n = ndig + 1;
        bad_at = (kind == 14) ? $urandom_range(0, n - 1) : -1;
        repeat (lead) send_char(CH_SPACE, 1'b0);
        if (kind >= 18) begin
            // blank field: spaces at most
        end else if (kind >= 16) begin
            repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            for (int i = 0; i < n; i++) begin
                if (i == bad_at) send_char(stray_char(base), 1'b0);
                send_char(digit_char(base), 1'b0);
            end
            if (kind == 15) begin
                send_char(CH_SPACE, 1'b0);
                send_char(digit_char(base), 1'b0);
            end
        end
        repeat (trail) send_char(CH_SPACE, 1'b0);
        if (field_open || kind >= 18) begin
            t = $urandom_range(0, 3);
            if (t == 0 && reg_delim[0]) begin
                send_char(CH_COMMA, 1'b0);
            end else if (t == 1 && reg_delim[1]) begin
                send_char(CH_NEWLINE, 1'b0);
            end else if (t != 3 && fld_left <= 8'd24) begin
                do send_char(CH_SPACE, 1'b0); while (field_open);
            end else begin
                send_char(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    task automatic run_phase(input logic [2:0] radix, input logic [6:0] len,
                             input logic [7:0] width, input logic [1:0] delim, input int n_chars);
        int start;
        set_format(radix, len, width, delim);
        start = chars_sent;
        while (chars_sent - start < n_chars) begin
            send_random_field();
            if ($urandom_range(0, 49) == 0) wait_fields_done();
        end
    endtask

    // ---------------- tests ----------------

    // Reset leaves binary, length 1, width 1: every character is a field of its own
    task automatic test_reset_defaults();
        send_text("01 x");
    endtask

    task automatic test_hex_fields();
        set_format(RADIX_HEX, 7'd16, 8'd6, DELIM_BOTH);
        send_text(" a");
        // an unused index must not restart the half-read field
        wait_fields_done();
        write_reg(CFG_UNUSED_FIRST + 3'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        send_text("F09 ");
        send_text("12345,");
        send_text(",\n");
        send_text("g");
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Octal length 4: the second digit carries two padding bits
    task automatic test_octal_padding();
        set_format(RADIX_OCT, 7'd4, 8'd3, DELIM_NONE);
        send_text("17,");
        send_text("14 ");
        send_text("17");
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_random_fields();
        run_phase(RADIX_HEX, 7'd16, 8'd12, DELIM_BOTH, 90);
        run_phase(RADIX_BIN, 7'd8, 8'd12, DELIM_COMMA, 90);
        run_phase(RADIX_QUAD, 7'd7, 8'd10, DELIM_NEWLINE, 80);
        run_phase(RADIX_OCT, 7'd64, 8'd30, DELIM_BOTH, 90);
        run_phase(3'd0, 7'd0, 8'd0, DELIM_NONE, 40);
        run_phase(3'd7, 7'd127, 8'd255, DELIM_BOTH, 90);
        run_phase(3'd5, 7'd65, 8'd1, DELIM_COMMA, 30);
        run_phase(3'd6, 7'd13, 8'd255, DELIM_NONE, 70);
        for (int p = 0; p < 3; p++) begin
            // middle phase runs without any idling on either side
            send_gaps   = (p != 1);
            recv_stalls = (p != 1);
            run_phase(3'($urandom_range(0, 7)), 7'($urandom_range(1, 24)),
                      8'($urandom_range(4, 32)), 2'($urandom_range(0, 3)), 80);
        end
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    task automatic test_quiet_tail();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        run_phase(RADIX_HEX, 7'd12, 8'd8, DELIM_BOTH, 110);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RADIX_BITS;
        cfg_data  = 8'd0;
        reg_radix  = RADIX_BIN;
        reg_length = 7'd1;
        reg_width  = 8'd1;
        reg_delim  = DELIM_NONE;
        field_restart();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_hex_fields();
        test_octal_padding();
        test_random_fields();
        test_quiet_tail();

        wait_fields_done();
        repeat (5) @(posedge aclk);
        if (fail_count == 0) begin
            $display("bit_string_field_parser_unit verification clean");
        end else begin
            $display("bit_string_field_parser_unit verification failed");
        end
        $finish;
    end

endmodule
